@@ sv/poah_pkg.sv @@
// Shared types, constants and helpers for the page offset access histogram.
package poah_pkg;

  localparam int BIN_BITS    = 8;
  localparam int LINE_SHIFT  = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int NUM_BINS    = 1 << BIN_BITS;

  localparam int FUNC_WIDTH    = 3;
  localparam int ADDR_WIDTH    = 48;
  localparam int BIN_FIELD_W   = 8;
  localparam int COUNT_FIELD_W = 32;

  localparam int CMD_Q_DEPTH = 2;
  localparam int CMD_Q_PTR_W = $clog2(CMD_Q_DEPTH);
  localparam int CMD_Q_CNT_W = $clog2(CMD_Q_DEPTH + 1);

  localparam int OUT_Q_DEPTH = 2;
  localparam int OUT_Q_PTR_W = $clog2(OUT_Q_DEPTH);
  localparam int OUT_Q_CNT_W = $clog2(OUT_Q_DEPTH + 1);

  typedef enum logic [FUNC_WIDTH-1:0] {
    FN_FETCH  = 3'd0,
    FN_LOAD   = 3'd1,
    FN_STORE  = 3'd2,
    FN_MODIFY = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef logic [BIN_BITS-1:0]      bin_idx_t;
  typedef logic [COUNT_WIDTH-1:0]   count_t;
  typedef logic [BIN_FIELD_W-1:0]   bin_field_t;
  typedef logic [COUNT_FIELD_W-1:0] count_field_t;

  typedef logic [CMD_Q_PTR_W-1:0] cmd_ptr_t;
  typedef logic [CMD_Q_CNT_W-1:0] cmd_cnt_t;
  typedef logic [OUT_Q_PTR_W-1:0] out_ptr_t;
  typedef logic [OUT_Q_CNT_W-1:0] out_cnt_t;
  typedef logic [OUT_Q_CNT_W:0]   out_pend_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic [FUNC_WIDTH-1:0] func;
    logic [ADDR_WIDTH-1:0] address;
    bin_field_t            bin_index;
  } in_req_t;

  typedef struct packed {
    bin_field_t   bin;
    count_field_t all_count;
    count_field_t data_count;
    count_field_t code_count;
  } out_res_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    bin_idx_t sel;
    logic     upd;
    logic     fetch;
    logic     modify;
  } cmd_t;

  typedef struct packed {
    count_t all_cnt;
    count_t data_cnt;
    count_t code_cnt;
  } counts_t;

  function automatic count_t sat_add(count_t v, logic [1:0] inc);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, v} + {{(COUNT_WIDTH-1){1'b0}}, inc};
    return sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
  endfunction

endpackage

@@ sv/poah_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module poah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/poah_front.sv @@
// Front end: accepts requests, decodes them into commands and queues them.
module poah_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  poah_pkg::in_req_t in_req,
  output logic              cmd_valid,
  output poah_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  poah_pkg::cmd_t     cmd_in;
  poah_pkg::cmd_t     q_r [poah_pkg::CMD_Q_DEPTH];
  poah_pkg::cmd_ptr_t wr_ptr_r, wr_ptr_nxt;
  poah_pkg::cmd_ptr_t rd_ptr_r, rd_ptr_nxt;
  poah_pkg::cmd_cnt_t cnt_r, cnt_nxt;
  logic               push;

  always_comb begin
    cmd_in     = '0;
    cmd_in.sel = in_req.address[poah_pkg::LINE_SHIFT +: poah_pkg::BIN_BITS];
    unique case (in_req.func) inside
      poah_pkg::FN_FETCH: begin
        cmd_in.upd   = 1'b1;
        cmd_in.fetch = 1'b1;
      end
      poah_pkg::FN_LOAD, poah_pkg::FN_STORE: begin
        cmd_in.upd = 1'b1;
      end
      poah_pkg::FN_MODIFY: begin
        cmd_in.upd    = 1'b1;
        cmd_in.modify = 1'b1;
      end
      default: begin
        // Reads and unused codes only look up the requested bin.
        cmd_in.sel = poah_pkg::bin_idx_t'(in_req.bin_index);
      end
    endcase
  end

  assign in_ready  = (cnt_r != poah_pkg::cmd_cnt_t'(poah_pkg::CMD_Q_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == poah_pkg::cmd_ptr_t'(poah_pkg::CMD_Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == poah_pkg::cmd_ptr_t'(poah_pkg::CMD_Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + poah_pkg::cmd_cnt_t'(push) - poah_pkg::cmd_cnt_t'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ sv/poah_back.sv @@
// Back end: read-modify-write of the bin counters and the result queue.
module poah_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  poah_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output poah_pkg::out_res_t out_res
);

  logic [poah_pkg::NUM_BINS-1:0] vld_r, vld_nxt;

  logic                s2_v_r;
  poah_pkg::cmd_t      s2_cmd_r;
  logic                s2_vld_r;

  logic                fw_v_r;
  poah_pkg::bin_idx_t  fw_sel_r;
  poah_pkg::counts_t   fw_cnt_r;

  poah_pkg::counts_t   rd_cnt;
  poah_pkg::counts_t   cur_cnt;
  poah_pkg::counts_t   new_cnt;
  logic [1:0]          weight;
  logic                wr_en;
  poah_pkg::out_res_t  res;

  poah_pkg::out_res_t  oq_r [poah_pkg::OUT_Q_DEPTH];
  poah_pkg::out_ptr_t  owr_ptr_r, owr_ptr_nxt;
  poah_pkg::out_ptr_t  ord_ptr_r, ord_ptr_nxt;
  poah_pkg::out_cnt_t  ocnt_r, ocnt_nxt;
  poah_pkg::out_pend_t pend;
  logic                out_pop;
  logic                room;

  assign out_pop = out_valid && out_ready;

  // Issue only when the result of this command is sure to find a free slot.
  assign pend = {1'b0, ocnt_r} + poah_pkg::out_pend_t'(s2_v_r)
              - poah_pkg::out_pend_t'(out_pop);
  assign room    = (pend < poah_pkg::out_pend_t'(poah_pkg::OUT_Q_DEPTH));
  assign cmd_pop = cmd_valid && room;

  poah_ram #(
    .WIDTH ($bits(poah_pkg::counts_t)),
    .DEPTH (poah_pkg::NUM_BINS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_cmd_r.sel),
    .wdata (new_cnt),
    .raddr (cmd.sel),
    .rdata (rd_cnt)
  );

  // The write from the previous cycle is not yet visible in the read data.
  always_comb begin
    if (fw_v_r && (fw_sel_r == s2_cmd_r.sel)) begin
      cur_cnt = fw_cnt_r;
    end else if (s2_vld_r) begin
      cur_cnt = rd_cnt;
    end else begin
      cur_cnt = '0;
    end
  end

  always_comb begin
    weight  = s2_cmd_r.modify ? 2'd2 : 2'd1;
    new_cnt = cur_cnt;
    if (s2_cmd_r.upd) begin
      new_cnt.all_cnt = poah_pkg::sat_add(cur_cnt.all_cnt, weight);
      if (s2_cmd_r.fetch) begin
        new_cnt.code_cnt = poah_pkg::sat_add(cur_cnt.code_cnt, 2'd1);
      end else begin
        new_cnt.data_cnt = poah_pkg::sat_add(cur_cnt.data_cnt, weight);
      end
    end
  end

  assign wr_en = s2_v_r && s2_cmd_r.upd;

  always_comb begin
    res.bin        = poah_pkg::bin_field_t'(s2_cmd_r.sel);
    res.all_count  = poah_pkg::count_field_t'(new_cnt.all_cnt);
    res.data_count = poah_pkg::count_field_t'(new_cnt.data_cnt);
    res.code_count = poah_pkg::count_field_t'(new_cnt.code_cnt);
  end

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[s2_cmd_r.sel] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      s2_v_r <= 1'b0;
      fw_v_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      s2_v_r <= cmd_pop;
      fw_v_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    s2_cmd_r <= cmd;
    s2_vld_r <= vld_r[cmd.sel];
    fw_sel_r <= s2_cmd_r.sel;
    fw_cnt_r <= new_cnt;
  end

  // Result queue.
  assign out_valid = (ocnt_r != '0);
  assign out_res   = oq_r[ord_ptr_r];

  always_comb begin
    owr_ptr_nxt = owr_ptr_r;
    ord_ptr_nxt = ord_ptr_r;
    if (s2_v_r) begin
      owr_ptr_nxt = (owr_ptr_r == poah_pkg::out_ptr_t'(poah_pkg::OUT_Q_DEPTH - 1)) ?
                    '0 : owr_ptr_r + 1'b1;
    end
    if (out_pop) begin
      ord_ptr_nxt = (ord_ptr_r == poah_pkg::out_ptr_t'(poah_pkg::OUT_Q_DEPTH - 1)) ?
                    '0 : ord_ptr_r + 1'b1;
    end
    ocnt_nxt = ocnt_r + poah_pkg::out_cnt_t'(s2_v_r) - poah_pkg::out_cnt_t'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      oq_r[owr_ptr_r] <= res;
    end
  end

`ifndef SYNTHESIS
  a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (ocnt_r != poah_pkg::out_cnt_t'(poah_pkg::OUT_Q_DEPTH)) || out_pop)
    else $error("result queue overflow");

  a_written_bin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(s2_cmd_r.sel)])
    else $error("updated bin not marked as written");

  a_total_dominates: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (new_cnt.all_cnt >= new_cnt.data_cnt) &&
               (new_cnt.all_cnt >= new_cnt.code_cnt))
    else $error("total count below data or code count");
`endif

endmodule

@@ sv/page_offset_access_histogram_top.sv @@
// Top level of the page offset access histogram.
//
// Each request on the in_ channel carries an access type, a byte address
// and a bin number. Fetch, load, store and modify requests add to the bin
// picked by address bits 11..4 (a modify adds 2, the others 1); a read
// request, or any unused type code, looks up the bin given in bin_index.
// Every request produces exactly one result on the out_ channel, holding
// the bin number and its total, data and code counts after the update.
// Counts saturate at their maximum value.
// A result is offered once its request has passed the command queue, the
// counter update stage and the result queue; one request is taken every
// cycle while the out_ channel is not stalled.
// The rate is set by the counter RAM, which takes one read-modify-write
// per cycle with the previous write forwarded into the next update.
// While the receiver stalls, up to two results wait in the output queue
// and up to two requests in the command queue; then in_ready drops.
// Reset clears all counts at once through per-bin written flags, so the
// block takes requests in the first cycle after reset.
module page_offset_access_histogram_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  poah_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output poah_pkg::out_res_t out_res
);

  logic           cmd_valid;
  logic           cmd_pop;
  poah_pkg::cmd_t cmd;

  poah_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  poah_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule
